[rtl/core/disparity_to_depth_converter_defines.svh]
// Assertion macros shared by the checker of the disparity to depth converter.
// Depends on nothing; included by name from the files that assert.
`ifndef DISPARITY_TO_DEPTH_CONVERTER_DEFINES_SVH
`define DISPARITY_TO_DEPTH_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define D2D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define D2D_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/dd2d_pkg.sv]
// Types and constants of the disparity to depth converter.
// Used by every module of the block; depends on nothing.
package dd2d_pkg;

   localparam int unsigned FB_W               = 24;
   localparam int unsigned DISP_W             = 16;
   localparam int unsigned DEPTH_W            = 16;
   localparam int unsigned QUOT_BITS          = 16;
   localparam int unsigned CSR_INDEX_W        = 8;
   localparam int unsigned CSR_DATA_W         = 32;
   localparam int unsigned DISP_FRAC_BITS_DEF = 5;

   localparam logic [FB_W-1:0] FB_PRODUCT_RESET = 24'd127800;

   localparam logic [CSR_INDEX_W-1:0] REG_FB_PRODUCT   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH_ENABLE = 8'd1;

   typedef enum logic [1:0] {
      ST_VALID    = 2'd0,
      ST_RANGE    = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_DISABLED = 2'd3
   } status_type;

   // Working word of the divider as it moves down the row of cells.
   typedef struct packed {
      logic [DISP_W-1:0]    rem;
      logic [QUOT_BITS-1:0] low;
      logic [QUOT_BITS-1:0] quot;
      logic [DISP_W-1:0]    divisor;
   } word_type;

   // Per-pixel information that rides alongside the divider word.
   typedef struct packed {
      status_type status;
      logic       frame_end;
   } side_type;

endpackage

[rtl/core/disparity_to_depth_converter.sv]
// Disparity to depth converter: depth_mm = floor(fb_product * 2^F / disparity_q).
// From input transfer to result a pixel passes one entry cell, sixteen division
// cells (one quotient bit each) and the output register.
// Throughput one pixel per cycle; the row of cells advances as one and stops
// only while the skid register behind the output holds a result.
// Synchronous active-high reset clears all valid bits and loads the CSR defaults.
module disparity_to_depth_converter #(
   parameter int unsigned DISP_FRAC_BITS = dd2d_pkg::DISP_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // [15:0] disparity_q
   input  logic                              req_tlast,   // last_pixel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // [15:0] depth_mm
   output logic [1:0]                        rsp_tuser,   // [1:0] status
   output logic                              rsp_tlast,   // frame_end
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dd2d_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dd2d_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int unsigned NCELLS = dd2d_pkg::QUOT_BITS;

   logic [dd2d_pkg::FB_W-1:0]    fb_product_ff;
   logic                         depth_enable_ff;
   logic                         adv;
   logic                         arrive;
   logic                         out_load;
   logic [NCELLS:0]              stage_valid;
   dd2d_pkg::word_type           stage_word [NCELLS+1];
   dd2d_pkg::side_type           stage_side [NCELLS+1];
   logic [dd2d_pkg::DEPTH_W-1:0] fin_depth;
   dd2d_pkg::status_type         fin_status;
   logic                         out_valid_ff, skid_valid_ff;
   logic [dd2d_pkg::DEPTH_W-1:0] out_depth_ff, skid_depth_ff;
   dd2d_pkg::status_type         out_status_ff, skid_status_ff;
   logic                         out_last_ff, skid_last_ff;

   // Configuration registers; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_product_ff   <= dd2d_pkg::FB_PRODUCT_RESET;
         depth_enable_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            dd2d_pkg::REG_FB_PRODUCT:   fb_product_ff   <= csr_data[dd2d_pkg::FB_W-1:0];
            dd2d_pkg::REG_DEPTH_ENABLE: depth_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // The row moves whenever the skid register is free.
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   dd2d_front #(
      .DISP_FRAC_BITS (DISP_FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req_tvalid),
      .disparity_q  (req_tdata),
      .last_pixel   (req_tlast),
      .fb_product   (fb_product_ff),
      .depth_enable (depth_enable_ff),
      .valid_out    (stage_valid[0]),
      .word_out     (stage_word[0]),
      .side_out     (stage_side[0])
   );

   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      dd2d_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .valid_in  (stage_valid[i]),
         .word_in   (stage_word[i]),
         .side_in   (stage_side[i]),
         .valid_out (stage_valid[i+1]),
         .word_out  (stage_word[i+1]),
         .side_out  (stage_side[i+1])
      );
   end

   // A quotient of exactly 65535 is still an overflow.
   always_comb begin
      fin_status = stage_side[NCELLS].status;
      if (fin_status == dd2d_pkg::ST_VALID && (&stage_word[NCELLS].quot)) begin
         fin_status = dd2d_pkg::ST_OVERFLOW;
      end
      fin_depth = (fin_status == dd2d_pkg::ST_VALID)
                ? stage_word[NCELLS].quot : '0;
   end

   assign arrive   = adv && stage_valid[NCELLS];
   assign out_load = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff  <= skid_valid_ff || arrive;
         skid_valid_ff <= 1'b0;
      end else if (arrive) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (skid_valid_ff) begin
            out_depth_ff  <= skid_depth_ff;
            out_status_ff <= skid_status_ff;
            out_last_ff   <= skid_last_ff;
         end else begin
            out_depth_ff  <= fin_depth;
            out_status_ff <= fin_status;
            out_last_ff   <= stage_side[NCELLS].frame_end;
         end
      end else if (arrive) begin
         skid_depth_ff  <= fin_depth;
         skid_status_ff <= fin_status;
         skid_last_ff   <= stage_side[NCELLS].frame_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_depth_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[rtl/core/dd2d_front.sv]
// Entry cell of the converter: range and enable checks, high-part overflow test
// and loading of the divider word. Depends on dd2d_pkg.
module dd2d_front #(
   parameter int unsigned DISP_FRAC_BITS = dd2d_pkg::DISP_FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [dd2d_pkg::DISP_W-1:0]  disparity_q,
   input  logic                         last_pixel,
   input  logic [dd2d_pkg::FB_W-1:0]    fb_product,
   input  logic                         depth_enable,
   output logic                         valid_out,
   output dd2d_pkg::word_type           word_out,
   output dd2d_pkg::side_type           side_out
);

   localparam int unsigned DVD_W = dd2d_pkg::FB_W + DISP_FRAC_BITS;
   localparam int unsigned SCALE = 1 << DISP_FRAC_BITS;
   localparam logic [dd2d_pkg::DISP_W+3:0] DISP_LOW  = (dd2d_pkg::DISP_W+4)'(SCALE);
   localparam logic [dd2d_pkg::DISP_W+1:0] DISP_HIGH = (dd2d_pkg::DISP_W+2)'(1000 * SCALE);

   logic [DVD_W-1:0]                          dividend;
   logic [DVD_W-dd2d_pkg::QUOT_BITS-1:0]      dvd_high;
   logic [dd2d_pkg::DISP_W+3:0]               disp_x10;
   logic                                      in_range;
   logic                                      high_ovf;
   logic                                      valid_ff;
   dd2d_pkg::word_type                        word_in, word_ff;
   dd2d_pkg::side_type                        side_in, side_ff;

   always_comb begin
      dividend = DVD_W'(fb_product) << DISP_FRAC_BITS;
      dvd_high = dividend[DVD_W-1:dd2d_pkg::QUOT_BITS];
      disp_x10 = ((dd2d_pkg::DISP_W+4)'(disparity_q) << 3)
               + ((dd2d_pkg::DISP_W+4)'(disparity_q) << 1);
      in_range = (disp_x10 > DISP_LOW)
               && ((dd2d_pkg::DISP_W+2)'(disparity_q) < DISP_HIGH);
      // A quotient of 2^16 or more shows already in the upper dividend bits.
      high_ovf = (dd2d_pkg::DISP_W+1)'(dvd_high) >= (dd2d_pkg::DISP_W+1)'(disparity_q);

      word_in.rem     = dd2d_pkg::DISP_W'(dvd_high);
      word_in.low     = dividend[dd2d_pkg::QUOT_BITS-1:0];
      word_in.quot    = '0;
      word_in.divisor = disparity_q;

      side_in.frame_end = last_pixel;
      if (!depth_enable) begin
         side_in.status = dd2d_pkg::ST_DISABLED;
      end else if (!in_range) begin
         side_in.status = dd2d_pkg::ST_RANGE;
      end else if (high_ovf) begin
         side_in.status = dd2d_pkg::ST_OVERFLOW;
      end else begin
         side_in.status = dd2d_pkg::ST_VALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         word_ff <= word_in;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign word_out  = word_ff;
   assign side_out  = side_ff;

endmodule

[rtl/core/dd2d_cell.sv]
// One restoring-division cell: produces one quotient bit and hands the word on.
// Depends on dd2d_pkg.
module dd2d_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                valid_in,
   input  dd2d_pkg::word_type  word_in,
   input  dd2d_pkg::side_type  side_in,
   output logic                valid_out,
   output dd2d_pkg::word_type  word_out,
   output dd2d_pkg::side_type  side_out
);

   logic [dd2d_pkg::DISP_W:0] trial;
   logic [dd2d_pkg::DISP_W:0] diff;
   logic                      take;
   logic                      valid_ff;
   dd2d_pkg::word_type        word_nx_in, word_ff;
   dd2d_pkg::side_type        side_ff;

   always_comb begin
      trial = {word_in.rem, word_in.low[dd2d_pkg::QUOT_BITS-1]};
      diff  = trial - {1'b0, word_in.divisor};
      take  = trial >= {1'b0, word_in.divisor};

      // The remainder stays below the divisor, so it always fits in DISP_W bits.
      word_nx_in.rem     = take ? diff[dd2d_pkg::DISP_W-1:0] : trial[dd2d_pkg::DISP_W-1:0];
      word_nx_in.low     = word_in.low << 1;
      word_nx_in.quot    = {word_in.quot[dd2d_pkg::QUOT_BITS-2:0], take};
      word_nx_in.divisor = word_in.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         word_ff <= word_nx_in;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign word_out  = word_ff;
   assign side_out  = side_ff;

endmodule

[rtl/core/dd2d_checker.sv]
// Port-level checker of the disparity to depth converter, bound to the top level.
// Depends on dd2d_pkg and disparity_to_depth_converter_defines.svh.
`include "disparity_to_depth_converter_defines.svh"

module dd2d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   `D2D_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_tvalid && rsp_tuser != dd2d_pkg::ST_VALID, rsp_tdata == 16'd0, "depth not zero on a flagged pixel")

   `D2D_ASSERT_IMP(a_depth_limit, clock, reset, rsp_tvalid && rsp_tuser == dd2d_pkg::ST_VALID, rsp_tdata != 16'hFFFF, "valid depth at overflow limit")

   `D2D_ASSERT_IMP(a_stall_source, clock, reset, !req_tready, rsp_tvalid, "input stalled with no result waiting")

   `D2D_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result transfer changed")

endmodule

bind disparity_to_depth_converter dd2d_checker u_dd2d_checker (.*);
